### src/lnbt_pkg.sv
// Shared types and constants for the LMS neuron bank trainer.
// No dependencies; imported by every module of the block except lnbt_ram.
package lnbt_pkg;

    localparam int NEURONS_DEF = 10;
    localparam int PIXELS_DEF  = 48;

    localparam int IN_PIX  = 48;
    localparam int W_W     = 24;
    localparam int ACC_W   = 32;
    localparam int RATE_W  = 16;
    localparam int PROD_W  = RATE_W + 1 + ACC_W;
    localparam int DELTA_W = PROD_W - 16;
    localparam int SUM_W   = DELTA_W + 1;

    localparam logic signed [W_W-1:0]   W_MAX   = {1'b0, {(W_W-1){1'b1}}};
    localparam logic signed [W_W-1:0]   W_MIN   = {1'b1, {(W_W-1){1'b0}}};
    localparam logic signed [ACC_W-1:0] ONE_Q16 = 32'sd65536;
    localparam logic signed [PROD_W-1:0] RND_HALF = PROD_W'(32768);

    typedef enum logic [1:0] {
        ACT_LOAD  = 2'd0,
        ACT_TRAIN = 2'd1,
        ACT_EVAL  = 2'd2,
        ACT_NONE  = 2'd3
    } action_t;

    localparam logic [1:0] CFG_LEARN_RATE = 2'd0;
    localparam logic [1:0] CFG_TOLERANCE  = 2'd1;

    localparam logic [RATE_W-1:0] LEARN_RATE_RST = 16'd655;
    localparam logic [RATE_W-1:0] TOLERANCE_RST  = 16'd6554;

    typedef struct packed {
        logic capture;
        logic clr_step;
        logic load_wr;
        logic scan_start;
        logic acc_clr;
        logic scan_rd;
        logic upd_mode;
        logic calc_err;
        logic calc_mul;
        logic calc_delta;
        logic result_load;
    } lnbt_cmd_t;

    typedef struct packed {
        logic    clr_last;
        logic    scan_end;
        logic    rd_pending;
        logic    nrn_ok;
        logic    widx_ok;
        action_t act;
        logic    out_free;
    } lnbt_sts_t;

endpackage

### src/lnbt_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module lnbt_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 480
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### src/lnbt_ctrl.sv
// Sequencer of the LMS neuron bank trainer: clear pass, sum pass, update pass.
// Depends on lnbt_pkg; drives the datapath only through lnbt_cmd_t.
module lnbt_ctrl
    import lnbt_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  lnbt_sts_t sts,
    output lnbt_cmd_t cmd
);

    typedef enum logic [7:0] {
        S_CLEAR    = 8'b0000_0001,
        S_IDLE     = 8'b0000_0010,
        S_DISPATCH = 8'b0000_0100,
        S_SUM      = 8'b0000_1000,
        S_ERR      = 8'b0001_0000,
        S_MUL      = 8'b0010_0000,
        S_UPD      = 8'b0100_0000,
        S_DONE     = 8'b1000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                state_next = S_DONE;
                if (sts.nrn_ok && sts.act == ACT_LOAD)
                begin
                    cmd.load_wr = sts.widx_ok;
                end
                else if (sts.nrn_ok && (sts.act inside {ACT_TRAIN, ACT_EVAL}))
                begin
                    cmd.scan_start = 1'b1;
                    cmd.acc_clr    = 1'b1;
                    state_next     = S_SUM;
                end
            end
            S_SUM:
            begin
                if (!sts.scan_end)
                begin
                    cmd.scan_rd = 1'b1;
                end
                else if (!sts.rd_pending)
                begin
                    state_next = S_ERR;
                end
            end
            S_ERR:
            begin
                cmd.calc_err = 1'b1;
                state_next   = (sts.act == ACT_TRAIN) ? S_MUL : S_DONE;
            end
            S_MUL:
            begin
                cmd.calc_mul   = 1'b1;
                cmd.scan_start = 1'b1;
                state_next     = S_UPD;
            end
            S_UPD:
            begin
                // delta is ready before the first write-back of the pass
                cmd.calc_delta = 1'b1;
                if (sts.scan_end && !sts.rd_pending)
                begin
                    state_next = S_DONE;
                end
                else if (!sts.scan_end)
                begin
                    cmd.scan_rd  = 1'b1;
                    cmd.upd_mode = 1'b1;
                end
            end
            S_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.result_load = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign in_stall = (state_reg != S_IDLE);

endmodule

### src/lnbt_dp.sv
// Datapath of the LMS neuron bank trainer: item and config registers, weight
// RAM, accumulator, error/rate multiply, saturating update, result register.
// Depends on lnbt_pkg and lnbt_ram.
module lnbt_dp
    import lnbt_pkg::*;
#(
    parameter int NEURONS = NEURONS_DEF,
    parameter int PIXELS  = PIXELS_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic [1:0]               action,
    input  logic [3:0]               neuron,
    input  logic [IN_PIX-1:0]        pixels,
    input  logic [5:0]               weight_index,
    input  logic signed [W_W-1:0]    weight_value,
    input  logic                     cfg_valid,
    input  logic [1:0]               cfg_index,
    input  logic [RATE_W-1:0]        cfg_data,
    input  lnbt_cmd_t                cmd,
    output lnbt_sts_t                sts,
    input  logic                     out_stall,
    output logic                     out_valid,
    output logic signed [ACC_W-1:0]  potential,
    output logic signed [ACC_W-1:0]  error,
    output logic                     within_tolerance
);

    localparam int DEPTH  = NEURONS * PIXELS;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int IDX_W  = (PIXELS > 1) ? $clog2(PIXELS) : 1;
    localparam int CNT_W  = $clog2(PIXELS + 1);
    localparam int MASK_N = (PIXELS < IN_PIX) ? PIXELS : IN_PIX;

    action_t                   act_reg;
    logic [3:0]                nrn_reg;
    logic [PIXELS-1:0]         mask_reg;
    logic [PIXELS-1:0]         mask_next;
    logic [5:0]                widx_reg;
    logic [W_W-1:0]            wval_reg;
    logic [ADDR_W-1:0]         base_reg;
    logic [CNT_W-1:0]          cnt_reg;
    logic [ADDR_W-1:0]         clr_cnt_reg;
    logic                      rd_vld_reg;
    logic [IDX_W-1:0]          rd_idx_reg;
    logic                      rd_upd_reg;
    logic signed [ACC_W-1:0]   acc_reg;
    logic signed [ACC_W-1:0]   err_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [PROD_W-1:0]  prod_next;
    logic signed [PROD_W-1:0]  rnd;
    logic signed [DELTA_W-1:0] delta_reg;
    logic [RATE_W-1:0]         rate_reg;
    logic [RATE_W-1:0]         tol_reg;
    logic                      out_valid_reg;
    logic signed [ACC_W-1:0]   pot_out_reg;
    logic signed [ACC_W-1:0]   err_out_reg;
    logic                      within_out_reg;

    logic                      we;
    logic [ADDR_W-1:0]         waddr;
    logic [W_W-1:0]            wdata;
    logic [ADDR_W-1:0]         raddr;
    logic [W_W-1:0]            rdata;
    logic                      lit;
    logic signed [SUM_W-1:0]   w_sum;
    logic [W_W-1:0]            w_sat;
    logic [ACC_W-1:0]          mag;
    logic                      res_zero;

    lnbt_ram #(
        .WIDTH (W_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_comb
    begin
        mask_next               = '0;
        mask_next[MASK_N-1:0]   = pixels[MASK_N-1:0];
    end

    assign lit   = mask_reg[rd_idx_reg];
    assign raddr = base_reg + ADDR_W'(cnt_reg);
    assign w_sum = SUM_W'($signed(rdata)) + SUM_W'(delta_reg);

    always_comb
    begin
        if (w_sum > SUM_W'(W_MAX))
        begin
            w_sat = W_MAX;
        end
        else if (w_sum < SUM_W'(W_MIN))
        begin
            w_sat = W_MIN;
        end
        else
        begin
            w_sat = w_sum[W_W-1:0];
        end
    end

    always_comb
    begin
        we    = 1'b0;
        waddr = clr_cnt_reg;
        wdata = '0;
        if (cmd.clr_step)
        begin
            we = 1'b1;
        end
        else if (cmd.load_wr)
        begin
            we    = 1'b1;
            waddr = base_reg + ADDR_W'(widx_reg);
            wdata = wval_reg;
        end
        else if (rd_vld_reg && rd_upd_reg && lit)
        begin
            we    = 1'b1;
            waddr = base_reg + ADDR_W'(rd_idx_reg);
            wdata = w_sat;
        end
    end

    assign prod_next = PROD_W'($signed({1'b0, rate_reg})) * PROD_W'(err_reg);
    assign rnd       = prod_reg + RND_HALF;
    assign mag       = err_reg[ACC_W-1] ? ACC_W'(-err_reg) : ACC_W'(err_reg);
    assign res_zero  = !(sts.nrn_ok && (act_reg == ACT_TRAIN || act_reg == ACT_EVAL));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_reg      <= LEARN_RATE_RST;
            tol_reg       <= TOLERANCE_RST;
            clr_cnt_reg   <= '0;
            cnt_reg       <= '0;
            rd_vld_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    CFG_LEARN_RATE: rate_reg <= cfg_data;
                    CFG_TOLERANCE:  tol_reg  <= cfg_data;
                    default:        ;
                endcase
            end
            if (cmd.clr_step)
            begin
                clr_cnt_reg <= clr_cnt_reg + ADDR_W'(1);
            end
            if (cmd.scan_start)
            begin
                cnt_reg <= '0;
            end
            else if (cmd.scan_rd)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
            rd_vld_reg <= cmd.scan_rd;
            if (cmd.result_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            act_reg  <= action_t'(action);
            nrn_reg  <= neuron;
            mask_reg <= mask_next;
            widx_reg <= weight_index;
            wval_reg <= weight_value;
            base_reg <= ADDR_W'(32'(neuron) * PIXELS);
        end
        rd_idx_reg <= cnt_reg[IDX_W-1:0];
        rd_upd_reg <= cmd.upd_mode;
        if (cmd.acc_clr)
        begin
            acc_reg <= '0;
        end
        else if (rd_vld_reg && !rd_upd_reg && lit)
        begin
            acc_reg <= acc_reg + ACC_W'($signed(rdata));
        end
        if (cmd.calc_err)
        begin
            err_reg <= ONE_Q16 - acc_reg;
        end
        if (cmd.calc_mul)
        begin
            prod_reg <= prod_next;
        end
        if (cmd.calc_delta)
        begin
            delta_reg <= $signed(rnd[PROD_W-1:16]);
        end
        if (cmd.result_load)
        begin
            pot_out_reg    <= res_zero ? '0 : acc_reg;
            err_out_reg    <= res_zero ? '0 : err_reg;
            within_out_reg <= res_zero ? 1'b0 : (mag <= ACC_W'(tol_reg));
        end
    end

    always_comb
    begin
        sts            = '0;
        sts.clr_last   = (clr_cnt_reg == ADDR_W'(DEPTH - 1));
        sts.scan_end   = (cnt_reg == CNT_W'(PIXELS));
        sts.rd_pending = rd_vld_reg;
        sts.nrn_ok     = (7'(nrn_reg) < 7'(NEURONS));
        sts.widx_ok    = (7'(widx_reg) < 7'(PIXELS));
        sts.act        = act_reg;
        sts.out_free   = !out_valid_reg || !out_stall;
    end

    assign out_valid        = out_valid_reg;
    assign potential        = pot_out_reg;
    assign error            = err_out_reg;
    assign within_tolerance = within_out_reg;

endmodule

### src/lms_neuron_bank_trainer_top.sv
// LMS neuron bank trainer: adaline delta-rule training over a binary retina.
// Input channel: in_valid/in_stall with action, neuron, pixels, weight_index,
// weight_value; an item is taken when in_valid is high and in_stall is low.
// Output channel: out_valid/out_stall with potential, error, within_tolerance;
// exactly one result item per input item, in order.
// Config channel: cfg_valid/cfg_ready, cfg_index 0 learn_rate, 1 tolerance;
// cfg_ready is always high, other indexes are ignored.
// One item at a time; the weight RAM has one read and one write port.
// From accept to out_valid: a load is written and an ignored item goes straight
// to the result, evaluate makes one sum pass over the row, train makes a sum
// pass, multiply, rounding and a read-modify-write pass. The next item can be
// taken in the cycle after the result is loaded into the output register.
// A result held by out_stall waits in the output register; the block then
// finishes its current item and holds it until the register frees.
// Reset: learn_rate 655, tolerance 6554, then a clearing pass over all
// NEURONS*PIXELS words zeroes all weights with in_stall high.
// Depends on lnbt_pkg, lnbt_ctrl, lnbt_dp, lnbt_ram.
module lms_neuron_bank_trainer_top
    import lnbt_pkg::*;
#(
    parameter int NEURONS = NEURONS_DEF,
    parameter int PIXELS  = PIXELS_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic [1:0]              action,
    input  logic [3:0]              neuron,
    input  logic [IN_PIX-1:0]       pixels,
    input  logic [5:0]              weight_index,
    input  logic signed [W_W-1:0]   weight_value,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic signed [ACC_W-1:0] potential,
    output logic signed [ACC_W-1:0] error,
    output logic                    within_tolerance,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [1:0]              cfg_index,
    input  logic [RATE_W-1:0]       cfg_data
);

    lnbt_cmd_t cmd;
    lnbt_sts_t sts;

    assign cfg_ready = 1'b1;

    lnbt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    lnbt_dp #(
        .NEURONS (NEURONS),
        .PIXELS  (PIXELS)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .action           (action),
        .neuron           (neuron),
        .pixels           (pixels),
        .weight_index     (weight_index),
        .weight_value     (weight_value),
        .cfg_valid        (cfg_valid),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .cmd              (cmd),
        .sts              (sts),
        .out_stall        (out_stall),
        .out_valid        (out_valid),
        .potential        (potential),
        .error            (error),
        .within_tolerance (within_tolerance)
    );

`ifndef ASSERT_OFF
    a_ram_write_excl: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.clr_step, cmd.load_wr, cmd.scan_rd, cmd.result_load}))
        else $error("conflicting datapath commands");

    a_capture_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |-> !sts.rd_pending)
        else $error("item captured with a RAM read in flight");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.result_load |-> sts.out_free)
        else $error("result loaded over an unaccepted result");

    a_result_shows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.result_load |=> out_valid)
        else $error("loaded result not presented");
`endif

endmodule

### sim/tb_top.sv
// Self-checking testbench for lms_neuron_bank_trainer_top: directed table, then random phases.
// Holds its own weight bank and predicts each result item; depends on lnbt_pkg and the RTL.
module tb_top;
    import lnbt_pkg::*;

    localparam int NRN          = NEURONS_DEF;
    localparam int PIX          = PIXELS_DEF;
    localparam int PHASE_ITEMS  = 475;
    localparam int HOLD_CYCLES  = 400;
    localparam int QUIET_LIMIT  = 5000;
    localparam int DRAIN_CYCLES = 2 * PIX + 16;
    localparam logic [IN_PIX-1:0] ALL_PIX = '1;

    localparam logic [RATE_W-1:0] LR_SET [4]  = '{16'd16384, 16'd65535, 16'd0, 16'd1};
    localparam logic [RATE_W-1:0] TOL_SET [4] = '{16'd6554, 16'd65535, 16'd0, 16'd3000};
    localparam int SRC_PCT [4] = '{18, 83, 0, 0};
    localparam int RCV_PCT [4] = '{83, 18, 0, 0};

    typedef struct packed {
        action_t               act;
        logic [3:0]            nrn;
        logic [IN_PIX-1:0]     pix;
        logic [5:0]            widx;
        logic signed [W_W-1:0] wval;
    } stim_t;

    typedef struct packed {
        logic signed [ACC_W-1:0] pot;
        logic signed [ACC_W-1:0] err;
        logic                    ok;
    } res_t;

    typedef struct packed {
        stim_t st;
        logic  chk;
        res_t  want;
    } dir_row_t;

    localparam res_t RZ = '0;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    in_valid = 1'b0;
    logic                    in_stall;
    logic [1:0]              action = ACT_LOAD;
    logic [3:0]              neuron = '0;
    logic [IN_PIX-1:0]       pixels = '0;
    logic [5:0]              weight_index = '0;
    logic signed [W_W-1:0]   weight_value = '0;
    logic                    out_valid;
    logic                    out_stall = 1'b0;
    logic signed [ACC_W-1:0] potential;
    logic signed [ACC_W-1:0] error;
    logic                    within_tolerance;
    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic [1:0]              cfg_index = CFG_LEARN_RATE;
    logic [RATE_W-1:0]       cfg_data = '0;

    logic signed [W_W-1:0] wt_bank [NRN][PIX];
    logic [RATE_W-1:0]     lr_q;
    logic [RATE_W-1:0]     tol_q;
    res_t                  neuron_results_q [$];
    int                    fails = 0;
    int                    quiet_cycles = 0;
    int                    src_idle_pct = 0;
    int                    rcv_idle_pct = 0;
    bit                    hold_go = 1'b0;

    dir_row_t dir_tbl [27] = '{
        '{'{ACT_EVAL, 4'd0, ALL_PIX, 6'd0, 24'sd0}, 1'b1, '{32'sd0, 32'sd65536, 1'b0}},
        '{'{ACT_LOAD, 4'd0, 48'h0, 6'd0, W_MAX}, 1'b1, RZ},
        '{'{ACT_LOAD, 4'd0, 48'h0, 6'd47, W_MIN}, 1'b1, RZ},
        '{'{ACT_EVAL, 4'd0, 48'h8000_0000_0001, 6'd0, 24'sd0}, 1'b1,
          '{-32'sd1, 32'sd65537, 1'b0}},
        '{'{ACT_LOAD, 4'd0, 48'h0, 6'd48, 24'sh123456}, 1'b1, RZ},
        '{'{ACT_LOAD, 4'd0, ALL_PIX, 6'd63, -24'sd1}, 1'b1, RZ},
        '{'{ACT_NONE, 4'd0, ALL_PIX, 6'd0, 24'sd5}, 1'b1, RZ},
        '{'{ACT_EVAL, 4'd10, ALL_PIX, 6'd0, 24'sd0}, 1'b1, RZ},
        '{'{ACT_TRAIN, 4'd15, ALL_PIX, 6'd0, 24'sd0}, 1'b1, RZ},
        '{'{ACT_LOAD, 4'd9, 48'h0, 6'd5, 24'sd65536}, 1'b1, RZ},
        '{'{ACT_EVAL, 4'd9, 48'h20, 6'd0, 24'sd0}, 1'b1, '{32'sd65536, 32'sd0, 1'b1}},
        '{'{ACT_TRAIN, 4'd9, 48'h20, 6'd0, 24'sd0}, 1'b1, '{32'sd65536, 32'sd0, 1'b1}},
        '{'{ACT_TRAIN, 4'd1, ALL_PIX, 6'd0, 24'sd0}, 1'b1, '{32'sd0, 32'sd65536, 1'b0}},
        '{'{ACT_EVAL, 4'd1, ALL_PIX, 6'd0, 24'sd0}, 1'b0, RZ},
        '{'{ACT_TRAIN, 4'd0, 48'h1, 6'd0, 24'sd0}, 1'b0, RZ},
        '{'{ACT_LOAD, 4'd2, 48'h0, 6'd0, W_MAX}, 1'b1, RZ},
        '{'{ACT_LOAD, 4'd2, 48'h0, 6'd1, W_MIN}, 1'b1, RZ},
        '{'{ACT_TRAIN, 4'd2, 48'h3, 6'd0, 24'sd0}, 1'b1, '{-32'sd1, 32'sd65537, 1'b0}},
        '{'{ACT_EVAL, 4'd2, 48'h1, 6'd0, 24'sd0}, 1'b0, RZ},
        '{'{ACT_LOAD, 4'd3, 48'h0, 6'd0, W_MIN}, 1'b1, RZ},
        '{'{ACT_LOAD, 4'd3, 48'h0, 6'd1, W_MAX}, 1'b1, RZ},
        '{'{ACT_LOAD, 4'd3, 48'h0, 6'd2, W_MAX}, 1'b1, RZ},
        '{'{ACT_TRAIN, 4'd3, 48'h7, 6'd0, 24'sd0}, 1'b0, RZ},
        '{'{ACT_LOAD, 4'd9, 48'h0, 6'd5, 24'sd58982}, 1'b1, RZ},
        '{'{ACT_EVAL, 4'd9, 48'h20, 6'd0, 24'sd0}, 1'b1, '{32'sd58982, 32'sd6554, 1'b1}},
        '{'{ACT_LOAD, 4'd9, 48'h0, 6'd5, 24'sd72090}, 1'b1, RZ},
        '{'{ACT_EVAL, 4'd9, 48'h20, 6'd0, 24'sd0}, 1'b1, '{32'sd72090, -32'sd6554, 1'b1}}
    };

    lms_neuron_bank_trainer_top i_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .action           (action),
        .neuron           (neuron),
        .pixels           (pixels),
        .weight_index     (weight_index),
        .weight_value     (weight_value),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .potential        (potential),
        .error            (error),
        .within_tolerance (within_tolerance),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic longint sat32(input longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    // Potential, error and tolerance flag of one item; applies load and train to the bank.
    function automatic res_t lms_step(input stim_t s);
        res_t   r;
        longint acc;
        longint err;
        longint mag;
        longint delta;
        longint w;
        r = '0;
        if (s.nrn >= NRN || s.act == ACT_NONE)
            return r;
        if (s.act == ACT_LOAD)
        begin
            if (s.widx < PIX)
                wt_bank[s.nrn][s.widx] = s.wval;
            return r;
        end
        acc = 0;
        for (int p = 0; p < PIX; p++)
            if (s.pix[p])
                acc += longint'(wt_bank[s.nrn][p]);
        acc = sat32(acc);
        err = sat32(64'sd65536 - acc);
        mag = (err < 0) ? -err : err;
        r.pot = acc[ACC_W-1:0];
        r.err = err[ACC_W-1:0];
        r.ok  = (mag <= longint'(tol_q));
        if (s.act == ACT_TRAIN)
        begin
            delta = (longint'(lr_q) * err + 64'sd32768) >>> 16;
            for (int p = 0; p < PIX; p++)
            begin
                if (s.pix[p])
                begin
                    w = longint'(wt_bank[s.nrn][p]) + delta;
                    if (w > longint'(W_MAX))
                        w = longint'(W_MAX);
                    if (w < longint'(W_MIN))
                        w = longint'(W_MIN);
                    wt_bank[s.nrn][p] = w[W_W-1:0];
                end
            end
        end
        return r;
    endfunction

    function automatic stim_t rand_stim();
        stim_t s;
        int    sel;
        s = '0;
        sel = $urandom_range(99);
        if (sel < 30)
            s.act = ACT_LOAD;
        else if (sel < 70)
            s.act = ACT_TRAIN;
        else if (sel < 95)
            s.act = ACT_EVAL;
        else
            s.act = ACT_NONE;
        sel = $urandom_range(99);
        if (sel < 80)
            s.nrn = 4'($urandom_range(3));
        else if (sel < 92)
            s.nrn = 4'($urandom_range(NRN - 1, 4));
        else
            s.nrn = 4'($urandom_range(15, NRN));
        sel = $urandom_range(99);
        if (sel < 55)
        begin
            // sparse masks let training converge into the tolerance band
            repeat ($urandom_range(1, 4))
                s.pix[$urandom_range(PIX - 1)] = 1'b1;
        end
        else if (sel < 75)
            s.pix = IN_PIX'({$urandom(), $urandom()});
        else if (sel < 85)
            s.pix = IN_PIX'({$urandom(), $urandom()} & {$urandom(), $urandom()});
        else if (sel < 93)
            s.pix = ALL_PIX;
        s.widx = ($urandom_range(99) < 92) ? 6'($urandom_range(PIX - 1))
                                           : 6'($urandom_range(63, PIX));
        sel = $urandom_range(99);
        if (sel < 10)
            s.wval = W_MAX;
        else if (sel < 20)
            s.wval = W_MIN;
        else if (sel < 65)
            s.wval = W_W'($urandom_range(262143)) - 24'sd131072;
        else
            s.wval = W_W'($urandom());
        return s;
    endfunction

    task automatic send_item(input stim_t s, input bit typed, input res_t typed_res);
        res_t r;
        @(negedge clk);
        while ($urandom_range(99) < src_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid     <= 1'b1;
        action       <= s.act;
        neuron       <= s.nrn;
        pixels       <= s.pix;
        weight_index <= s.widx;
        weight_value <= s.wval;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        r = lms_step(s);
        neuron_results_q.insert(neuron_results_q.size(), typed ? typed_res : r);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [RATE_W-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx == CFG_LEARN_RATE)
            lr_q = val;
        else if (idx == CFG_TOLERANCE)
            tol_q = val;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain_items();
        @(negedge clk);
        in_valid <= 1'b0;
        while (neuron_results_q.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        forever
        begin
            @(negedge clk);
            if (hold_go)
            begin
                hold_go = 1'b0;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            out_stall <= ($urandom_range(99) < rcv_idle_pct);
        end
    end

    initial
    begin
        res_t want;
        forever
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (out_valid && !out_stall)
            begin
                if (neuron_results_q.size() == 0)
                begin
                    $error("result item with nothing expected");
                    fails++;
                end
                else
                begin
                    want = neuron_results_q.pop_front();
                    if (potential !== want.pot)
                    begin
                        $error("potential: expected %0d, got %0d", want.pot, potential);
                        fails++;
                    end
                    if (error !== want.err)
                    begin
                        $error("error: expected %0d, got %0d", want.err, error);
                        fails++;
                    end
                    if (within_tolerance !== want.ok)
                    begin
                        $error("within_tolerance: expected %0d, got %0d", want.ok,
                               within_tolerance);
                        fails++;
                    end
                end
            end
        end
    end

    initial
    begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        for (int n = 0; n < NRN; n++)
            for (int p = 0; p < PIX; p++)
                wt_bank[n][p] = '0;
        lr_q  = LEARN_RATE_RST;
        tol_q = TOLERANCE_RST;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (dir_tbl[k])
            send_item(dir_tbl[k].st, dir_tbl[k].chk, dir_tbl[k].want);

        for (int ph = 0; ph < 4; ph++)
        begin
            drain_items();
            write_reg(CFG_LEARN_RATE, LR_SET[ph]);
            write_reg(CFG_TOLERANCE, TOL_SET[ph]);
            src_idle_pct = SRC_PCT[ph];
            rcv_idle_pct = RCV_PCT[ph];
            if (ph == 2)
                hold_go = 1'b1;
            for (int k = 0; k < PHASE_ITEMS; k++)
                send_item(rand_stim(), 1'b0, RZ);
        end

        drain_items();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fails == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
